[rtl/ecr_pkg.sv]
// ----------------------------------------------------------------------------
// ecr_pkg: shared types and constants for the elevation colour ramp
// Field widths, configuration register indices and the queue item format
// passed from the classifier to the interpolation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecr_pkg;

  // Payload widths
  localparam int ELEV_W     = 16;
  localparam int CHAN_W     = 8;
  localparam int COL_W      = 3 * CHAN_W;
  localparam int STOP_W     = ELEV_W + COL_W;
  localparam int T_W        = 16;

  // Ramp size
  localparam int MAX_STOPS  = 6;
  localparam int CNT_W      = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = STOP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_COUNT = 3'd0,
    CFG_STOP_0     = 3'd1,
    CFG_STOP_1     = 3'd2,
    CFG_STOP_2     = 3'd3,
    CFG_STOP_3     = 3'd4,
    CFG_STOP_4     = 3'd5,
    CFG_STOP_5     = 3'd6
  } ecr_cfg_idx_t;

  // Reset ramp: two stops, black at sea level to white at 1000 m
  localparam logic [CNT_W-1:0]  STOP_COUNT_RST = 3'd2;
  localparam logic [STOP_W-1:0] STOP_1_RST     = 40'hFF_FFFF_03E8;

  // Decoupling queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // One classified beat: numerator and span of the segment weight and the
  // two end colours. Saturated cases carry num = 0 and span = 1.
  typedef struct packed {
    logic [T_W-1:0]   num;
    logic [T_W-1:0]   span;
    logic [COL_W-1:0] col_lo;
    logic [COL_W-1:0] col_hi;
  } ecr_item_t;

  typedef struct packed {
    logic      valid;
    ecr_item_t item;
  } ecr_q_wr_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } ecr_q_stat_t;

endpackage

`default_nettype wire

[rtl/ecr_if.sv]
// ----------------------------------------------------------------------------
// ecr_if: stream interfaces for the elevation colour ramp
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ecr_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ecr_pkg::ELEV_W-1:0]  elevation;

  modport source (output valid, output elevation, input ready);
  modport sink   (input valid, input elevation, output ready);
endinterface

interface ecr_out_if;
  logic                        valid;
  logic                        ready;
  logic [ecr_pkg::CHAN_W-1:0]  blue;
  logic [ecr_pkg::CHAN_W-1:0]  green;
  logic [ecr_pkg::CHAN_W-1:0]  red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

`default_nettype wire

[rtl/ecr_front.sv]
// ----------------------------------------------------------------------------
// ecr_front: configuration registers and segment classifier
// Holds the ramp, finds the segment for each accepted elevation and pushes
// the weight operands and end colours into the queue in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecr_front (
  input  wire                              clk,
  input  wire                              rst_n,
  ecr_in_if.sink                           in_ch,
  input  wire                              cfg_we,
  input  wire [ecr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [ecr_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ecr_pkg::ecr_q_wr_t               q_wr,
  input  wire                              q_full
);

  logic [ecr_pkg::CNT_W-1:0]  stop_count_r;
  logic [ecr_pkg::STOP_W-1:0] stop_r [ecr_pkg::MAX_STOPS];

  // Configuration write port; index beyond the last stop is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= ecr_pkg::STOP_COUNT_RST;
      for (int i = 0; i < ecr_pkg::MAX_STOPS; i++) begin
        stop_r[i] <= '0;
      end
      stop_r[1] <= ecr_pkg::STOP_1_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ecr_pkg::CFG_STOP_COUNT: stop_count_r <= cfg_data[ecr_pkg::CNT_W-1:0];
        ecr_pkg::CFG_STOP_0:     stop_r[0]    <= cfg_data;
        ecr_pkg::CFG_STOP_1:     stop_r[1]    <= cfg_data;
        ecr_pkg::CFG_STOP_2:     stop_r[2]    <= cfg_data;
        ecr_pkg::CFG_STOP_3:     stop_r[3]    <= cfg_data;
        ecr_pkg::CFG_STOP_4:     stop_r[4]    <= cfg_data;
        ecr_pkg::CFG_STOP_5:     stop_r[5]    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [ecr_pkg::CNT_W-1:0]           n_eff;
  logic [ecr_pkg::CNT_W-1:0]           last;
  logic signed [ecr_pkg::ELEV_W-1:0]   e;
  logic signed [ecr_pkg::ELEV_W-1:0]   first_e;
  logic signed [ecr_pkg::ELEV_W-1:0]   last_e;
  logic [ecr_pkg::COL_W-1:0]           last_col;
  logic                                seg_hit;
  logic signed [ecr_pkg::ELEV_W-1:0]   seg_lo_e;
  logic signed [ecr_pkg::ELEV_W-1:0]   seg_hi_e;
  logic [ecr_pkg::COL_W-1:0]           seg_col_lo;
  logic [ecr_pkg::COL_W-1:0]           seg_col_hi;
  logic signed [ecr_pkg::ELEV_W:0]     span;
  logic signed [ecr_pkg::ELEV_W:0]     num;
  logic                                interp;
  ecr_pkg::ecr_item_t                  item;

  // Effective stop count is clamped to the supported range
  always_comb begin
    if (stop_count_r < 3'd2) begin
      n_eff = 3'd2;
    end else if (stop_count_r > ecr_pkg::CNT_W'(ecr_pkg::MAX_STOPS)) begin
      n_eff = ecr_pkg::CNT_W'(ecr_pkg::MAX_STOPS);
    end else begin
      n_eff = stop_count_r;
    end
    last = n_eff - 3'd1;
  end

  // Segment search: lowest segment whose upper stop is above e wins
  always_comb begin
    e        = in_ch.elevation;
    first_e  = stop_r[0][ecr_pkg::ELEV_W-1:0];
    last_e   = first_e;
    last_col = stop_r[0][ecr_pkg::STOP_W-1:ecr_pkg::ELEV_W];
    for (int i = 0; i < ecr_pkg::MAX_STOPS; i++) begin
      if (last == ecr_pkg::CNT_W'(i)) begin
        last_e   = stop_r[i][ecr_pkg::ELEV_W-1:0];
        last_col = stop_r[i][ecr_pkg::STOP_W-1:ecr_pkg::ELEV_W];
      end
    end

    seg_hit    = 1'b0;
    seg_lo_e   = first_e;
    seg_hi_e   = first_e;
    seg_col_lo = last_col;
    seg_col_hi = last_col;
    for (int x = ecr_pkg::MAX_STOPS - 2; x >= 0; x--) begin
      if ((ecr_pkg::CNT_W'(x) < last) &&
          (e < $signed(stop_r[x+1][ecr_pkg::ELEV_W-1:0]))) begin
        seg_hit    = 1'b1;
        seg_lo_e   = stop_r[x][ecr_pkg::ELEV_W-1:0];
        seg_hi_e   = stop_r[x+1][ecr_pkg::ELEV_W-1:0];
        seg_col_lo = stop_r[x][ecr_pkg::STOP_W-1:ecr_pkg::ELEV_W];
        seg_col_hi = stop_r[x+1][ecr_pkg::STOP_W-1:ecr_pkg::ELEV_W];
      end
    end
  end

  // Build the queue beat
  always_comb begin
    span   = {seg_hi_e[ecr_pkg::ELEV_W-1], seg_hi_e} - {seg_lo_e[ecr_pkg::ELEV_W-1], seg_lo_e};
    num    = {e[ecr_pkg::ELEV_W-1], e} - {seg_lo_e[ecr_pkg::ELEV_W-1], seg_lo_e};
    interp = 1'b0;
    item.col_lo = last_col;
    item.col_hi = last_col;
    if (e < first_e) begin
      item.col_lo = stop_r[0][ecr_pkg::STOP_W-1:ecr_pkg::ELEV_W];
      item.col_hi = stop_r[0][ecr_pkg::STOP_W-1:ecr_pkg::ELEV_W];
    end else if (e >= last_e) begin
      item.col_lo = last_col;
      item.col_hi = last_col;
    end else if (seg_hit) begin
      item.col_lo = seg_col_lo;
      item.col_hi = seg_col_hi;
      // degenerate span or elevation under the lower stop: weight zero
      interp = !span[ecr_pkg::ELEV_W] && (span != '0) && !num[ecr_pkg::ELEV_W];
    end
    item.num  = interp ? num[ecr_pkg::T_W-1:0]  : '0;
    item.span = interp ? span[ecr_pkg::T_W-1:0] : ecr_pkg::T_W'(1);
  end

  assign in_ch.ready = !q_full;
  assign q_wr.valid  = in_ch.valid;
  assign q_wr.item   = item;

endmodule

`default_nettype wire

[rtl/ecr_queue.sv]
// ----------------------------------------------------------------------------
// ecr_queue: short decoupling queue between classifier and pipeline
// Four entries; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecr_queue (
  input  wire                       clk,
  input  wire                       rst_n,
  input  ecr_pkg::ecr_q_wr_t        q_wr,
  input  wire                       pop,
  output ecr_pkg::ecr_item_t        head,
  output ecr_pkg::ecr_q_stat_t      stat
);

  ecr_pkg::ecr_item_t               mem_r [ecr_pkg::Q_DEPTH];
  logic [ecr_pkg::Q_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ecr_pkg::Q_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ecr_pkg::Q_CNT_W-1:0]      count_r, count_nxt;
  logic                             do_push, do_pop;

  assign stat.full  = (count_r == ecr_pkg::Q_CNT_W'(ecr_pkg::Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;
  assign do_push    = q_wr.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.item;
    end
  end

endmodule

`default_nettype wire

[rtl/ecr_back.sv]
// ----------------------------------------------------------------------------
// ecr_back: weight divider, colour blend and output register
// Sixteen restoring division stages, one quotient bit each, then a
// multiply stage and an add into the output register. The whole pipeline
// advances whenever the output register can take a beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecr_back (
  input  wire                        clk,
  input  wire                        rst_n,
  input  ecr_pkg::ecr_item_t         head,
  input  wire                        q_empty,
  output logic                       pop,
  ecr_out_if.source                  out_ch
);

  localparam int NSTG  = ecr_pkg::T_W;
  localparam int PROD_W = ecr_pkg::CHAN_W + 1 + ecr_pkg::T_W + 1;

  typedef struct packed {
    logic [ecr_pkg::T_W-1:0]   rem;
    logic [ecr_pkg::T_W-1:0]   quo;
    logic [ecr_pkg::T_W-1:0]   span;
    logic [ecr_pkg::COL_W-1:0] col_lo;
    logic [ecr_pkg::COL_W-1:0] col_hi;
  } div_stg_t;

  // One restoring step: shift the remainder, subtract the span if it fits
  function automatic div_stg_t div_step(div_stg_t s);
    logic [ecr_pkg::T_W:0] r2;
    logic [ecr_pkg::T_W:0] diff;
    logic                  ge;
    div_stg_t              o;
    r2   = {s.rem, 1'b0};
    diff = r2 - {1'b0, s.span};
    ge   = (r2 >= {1'b0, s.span});
    o        = s;
    o.rem    = ge ? diff[ecr_pkg::T_W-1:0] : r2[ecr_pkg::T_W-1:0];
    o.quo    = {s.quo[ecr_pkg::T_W-2:0], ge};
    return o;
  endfunction

  logic                              adv;
  div_stg_t                          div_r   [NSTG];
  logic [NSTG-1:0]                   div_v_r;
  div_stg_t                          head_stg;
  logic signed [PROD_W-1:0]          prod_r  [3];
  logic [ecr_pkg::COL_W-1:0]         base_r;
  logic                              mul_v_r;
  logic signed [PROD_W-1:0]          prod_nxt [3];
  logic [ecr_pkg::CHAN_W-1:0]        chan_nxt [3];
  logic                              out_v_r;
  logic [ecr_pkg::CHAN_W-1:0]        out_chan_r [3];

  assign adv = !out_v_r || out_ch.ready;
  assign pop = adv && !q_empty;

  always_comb begin
    head_stg.rem    = head.num;
    head_stg.quo    = '0;
    head_stg.span   = head.span;
    head_stg.col_lo = head.col_lo;
    head_stg.col_hi = head.col_hi;
  end

  // Division pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0] <= div_step(head_stg);
      for (int k = 1; k < NSTG; k++) begin
        div_r[k] <= div_step(div_r[k-1]);
      end
    end
  end

  // Blend: a + (b - a) * t / 2^16, product registered per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_nxt[c] = PROD_W'(
          $signed({1'b0, div_r[NSTG-1].col_hi[c*ecr_pkg::CHAN_W +: ecr_pkg::CHAN_W]}) -
          $signed({1'b0, div_r[NSTG-1].col_lo[c*ecr_pkg::CHAN_W +: ecr_pkg::CHAN_W]})) *
          $signed(PROD_W'({1'b0, div_r[NSTG-1].quo}));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= prod_nxt[c];
      end
      base_r <= div_r[NSTG-1].col_lo;
    end
  end

  // Sum of base and scaled difference is never negative; keep the byte
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chan_nxt[c] = ecr_pkg::CHAN_W'(
          (PROD_W'({base_r[c*ecr_pkg::CHAN_W +: ecr_pkg::CHAN_W], {ecr_pkg::T_W{1'b0}}}) +
           prod_r[c]) >> ecr_pkg::T_W);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        out_chan_r[c] <= chan_nxt[c];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_v_r <= '0;
      mul_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      div_v_r <= {div_v_r[NSTG-2:0], !q_empty};
      mul_v_r <= div_v_r[NSTG-1];
      out_v_r <= mul_v_r;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.blue  = out_chan_r[0];
  assign out_ch.green = out_chan_r[1];
  assign out_ch.red   = out_chan_r[2];

endmodule

`default_nettype wire

[rtl/elevation_color_ramp.sv]
// Path: an accepted elevation passes the queue, 16 divider stages, multiply,
//   sum. Throughput: one beat per cycle unless the output stalls; the weight
//   divider is fully pipelined at one quotient bit per stage. A four-beat
//   queue absorbs output stalls.
// Reset (synchronous, rst_n low): two-stop ramp restored, queue and pipeline
//   emptied; no clearing pass.
// ----------------------------------------------------------------------------
// elevation_color_ramp: piecewise linear colour ramp over signed elevation
// Classifier with configuration registers, decoupling queue and an
// interpolation pipeline producing one RGB beat per elevation beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module elevation_color_ramp (
  input  wire                            clk,
  input  wire                            rst_n,
  ecr_in_if.sink                         in_ch,
  ecr_out_if.source                      out_ch,
  input  wire                            cfg_we,
  input  wire [ecr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [ecr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ecr_pkg::ecr_q_wr_t    q_wr;
  ecr_pkg::ecr_q_stat_t  q_stat;
  ecr_pkg::ecr_item_t    q_head;
  logic                  q_pop;

  ecr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_wr      (q_wr),
    .q_full    (q_stat.full)
  );

  ecr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  ecr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_stat.empty),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  // An accepted beat is in the queue at the next edge
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> q_stat.count != '0)
    else $error("accepted beat missing from queue");

  // A stalled output must freeze the pipeline, so nothing leaves the queue
  a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !q_pop)
    else $error("queue popped while output stalled");

  // Occupancy never passes the depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= ecr_pkg::Q_CNT_W'(ecr_pkg::Q_DEPTH))
    else $error("queue overflow");

endmodule

`default_nettype wire
